// ===== sv/sobel_pkg.sv =====
// Shared types and constants for the streaming Sobel edge threshold block.
// Used by sobel_grad and sobel_edge_threshold_stream_top.
package sobel_pkg;

  // Sizes
  localparam int MAX_WIDTH_DEFAULT = 1024;
  localparam int PIXEL_W           = 8;
  localparam int IMG_WIDTH_W       = 11;
  localparam int IMG_HEIGHT_W      = 16;
  localparam int THRESH_W          = 22;
  localparam int CFG_INDEX_W       = 2;
  localparam int CFG_DATA_W        = 22;
  localparam int GRAD_W            = 11;  // signed gradient, |g| <= 1020
  localparam int SQ_W              = 20;  // g*g <= 1040400
  localparam int MAG_W             = SQ_W + 1;
  localparam int OUT_FIFO_DEPTH    = 8;

  // Register map
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_WIDTH      = 2'd0,
    REG_IMAGE_HEIGHT     = 2'd1,
    REG_THRESHOLD_SQUARE = 2'd2
  } cfg_reg_t;

  localparam logic [IMG_WIDTH_W-1:0]  IMAGE_WIDTH_RESET  = 11'd1024;
  localparam logic [IMG_HEIGHT_W-1:0] IMAGE_HEIGHT_RESET = 16'd768;
  localparam logic [THRESH_W-1:0]     THRESHOLD_RESET    = 22'd16256;
  localparam int                      MIN_DIM            = 3;

  // Output pixel codes
  localparam logic [PIXEL_W-1:0] EDGE_PIXEL  = 8'd0;
  localparam logic [PIXEL_W-1:0] PLAIN_PIXEL = 8'd255;

  // Payloads
  typedef struct packed {
    logic [PIXEL_W-1:0] red_sample;
    logic               frame_start;
  } pixel_t;

  typedef struct packed {
    logic [PIXEL_W-1:0] edge_value;
    logic               frame_last;
  } result_t;

  // Per-stage control travelling alongside the window
  typedef struct packed {
    logic valid;
    logic interior;
    logic last;
  } stage_ctl_t;

  // 3x3 window, index row*3 + col, row 0 top, col 2 newest
  typedef logic [8:0][PIXEL_W-1:0] window_t;

endpackage

// ===== sv/sobel_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// A read at the address being written returns the old contents. No dependencies.
module sobel_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/sobel_grad.sv =====
// Gradient stage: Sobel kernels, squares, then squared magnitude against threshold.
// One register stage. Depends on sobel_pkg.
module sobel_grad (
  input  logic                          clk,
  input  logic                          rst,
  input  sobel_pkg::window_t            window,
  input  sobel_pkg::stage_ctl_t         ctl_in,
  input  logic [sobel_pkg::THRESH_W-1:0] threshold_square,
  output sobel_pkg::stage_ctl_t         ctl_out,
  output logic                          push,
  output sobel_pkg::result_t            result
);
  import sobel_pkg::*;

  localparam int SUM_W = GRAD_W - 1;  // 4*255 fits in 10 bits

  logic [SUM_W-1:0]         left_sum, right_sum, top_sum, bottom_sum;
  logic signed [GRAD_W-1:0] gx, gy;
  logic signed [2*GRAD_W-1:0] gx_full, gy_full;
  logic [SQ_W-1:0]          gx_sq, gy_sq;
  logic [MAG_W-1:0]         mag;

  // kernel sums, weights 1,2,1
  always_comb begin
    left_sum   = SUM_W'(window[0]) + SUM_W'({window[3], 1'b0}) + SUM_W'(window[6]);
    right_sum  = SUM_W'(window[2]) + SUM_W'({window[5], 1'b0}) + SUM_W'(window[8]);
    top_sum    = SUM_W'(window[0]) + SUM_W'({window[1], 1'b0}) + SUM_W'(window[2]);
    bottom_sum = SUM_W'(window[6]) + SUM_W'({window[7], 1'b0}) + SUM_W'(window[8]);
    gx = $signed({1'b0, right_sum}) - $signed({1'b0, left_sum});
    gy = $signed({1'b0, bottom_sum}) - $signed({1'b0, top_sum});
    gx_full = gx * gx;
    gy_full = gy * gy;
  end

  // squares registered
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out <= '0;
    end else begin
      ctl_out <= ctl_in;
    end
  end

  always_ff @(posedge clk) begin
    gx_sq <= gx_full[SQ_W-1:0];
    gy_sq <= gy_full[SQ_W-1:0];
  end

  // magnitude compare, result goes straight to the output queue
  always_comb begin
    mag               = MAG_W'(gx_sq) + MAG_W'(gy_sq);
    push              = ctl_out.valid && ctl_out.interior;
    result.edge_value = (THRESH_W'(mag) > threshold_square) ? EDGE_PIXEL : PLAIN_PIXEL;
    result.frame_last = ctl_out.last;
  end

endmodule

// ===== sv/sobel_edge_threshold_stream_top.sv =====
// Streaming 3x3 Sobel edge detector with squared-magnitude threshold.
// Depends on sobel_pkg, sobel_ram and sobel_grad.
//
// Usage
//   pixel channel : red samples in raster order, frame_start on the first pixel of
//                   a frame. A request is taken when pixel_valid is high and
//                   pixel_stall is low.
//   result channel: one result per interior pixel (column >= 2, row >= 2): 0 for an
//                   edge, 255 otherwise; frame_last on the bottom-right one. Border
//                   pixels give no result.
//   cfg port      : cfg_write / cfg_index / cfg_data, write only, while idle.
// Throughput: one pixel per clock, sustained while pixel_stall is low.
// Path: after its pixel is taken, a result passes the window update, the squares
//   and the compare into the output queue (the line store read is on the taking edge).
// Reset: synchronous. The two line stores are then swept to zero at one address per
//   cycle over all MAX_WIDTH addresses, during which pixel_stall stays high.
// Receiver stall: results wait in an 8-entry output queue; outside the reset sweep,
//   pixel_stall rises only when the queue plus the pixels in flight would fill it, so
//   nothing is lost and the head of the queue holds steady while result_stall is high.
module sobel_edge_threshold_stream_top #(
  parameter int MAX_WIDTH = sobel_pkg::MAX_WIDTH_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             pixel_valid,
  output logic                             pixel_stall,
  input  sobel_pkg::pixel_t                pixel,
  output logic                             result_valid,
  input  logic                             result_stall,
  output sobel_pkg::result_t               result,
  input  logic                             cfg_write,
  input  logic [sobel_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [sobel_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sobel_pkg::*;

  localparam int COL_W    = $clog2(MAX_WIDTH);
  localparam int CMP_W    = 15;  // holds any column or width up to 8192
  localparam int FIFO_AW  = $clog2(OUT_FIFO_DEPTH);
  localparam int FIFO_CW  = FIFO_AW + 1;

  // configuration registers
  logic [IMG_WIDTH_W-1:0]  image_width;
  logic [IMG_HEIGHT_W-1:0] image_height;
  logic [THRESH_W-1:0]     threshold_square;

  // position
  logic [COL_W-1:0]        column_count, column_next;
  logic [IMG_HEIGHT_W-1:0] row_count, row_next;

  // line store clearing sweep
  logic             clearing;
  logic [COL_W-1:0] clear_addr;

  // stage 1: line store read data arriving
  stage_ctl_t       s1_ctl;
  logic [COL_W-1:0] s1_col;
  logic [PIXEL_W-1:0] s1_pixel;
  logic             s1_bypass;
  logic [PIXEL_W-1:0] s1_bypass_upper, s1_bypass_middle;

  // stage 2: window
  window_t          window;
  stage_ctl_t       s2_ctl, s3_ctl;

  // output queue
  result_t          fifo_mem [OUT_FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0] fifo_count;

  logic               pixel_accept, result_take, push;
  result_t            grad_result;
  logic [FIFO_CW+1:0] claimed;

  logic [IMG_WIDTH_W-1:0]  w_use;
  logic [IMG_HEIGHT_W-1:0] h_use;
  logic [COL_W-1:0]        col_base, col_cur;
  logic [IMG_HEIGHT_W-1:0] row_base, row_cur;
  logic                    col_wrap, col_end, interior, last;
  logic [IMG_HEIGHT_W:0]   row_inc, row_step;
  logic [CMP_W-1:0]        col_step;

  logic [PIXEL_W-1:0] upper_rd, middle_rd, upper_eff, middle_eff;
  logic               ram_we;
  logic [COL_W-1:0]   ram_waddr;
  logic [PIXEL_W-1:0] upper_wdata, middle_wdata;

  // handshakes
  assign claimed      = (FIFO_CW+2)'(fifo_count) + (FIFO_CW+2)'(s1_ctl.valid)
                      + (FIFO_CW+2)'(s2_ctl.valid) + (FIFO_CW+2)'(s3_ctl.valid);
  assign pixel_stall  = clearing || (claimed >= (FIFO_CW+2)'(OUT_FIFO_DEPTH));
  assign pixel_accept = pixel_valid && !pixel_stall;
  assign result_valid = (fifo_count != '0);
  assign result_take  = result_valid && !result_stall;
  assign result       = fifo_mem[rd_ptr];

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width      <= IMAGE_WIDTH_RESET;
      image_height     <= IMAGE_HEIGHT_RESET;
      threshold_square <= THRESHOLD_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_IMAGE_WIDTH:      image_width      <= cfg_data[IMG_WIDTH_W-1:0];
        REG_IMAGE_HEIGHT:     image_height     <= cfg_data[IMG_HEIGHT_W-1:0];
        REG_THRESHOLD_SQUARE: threshold_square <= cfg_data[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  // frame size in use: width clamped to [3, MAX_WIDTH], height at least 3
  always_comb begin
    if (image_width < IMG_WIDTH_W'(MIN_DIM)) begin
      w_use = IMG_WIDTH_W'(MIN_DIM);
    end else if (CMP_W'(image_width) > CMP_W'(MAX_WIDTH)) begin
      w_use = IMG_WIDTH_W'(MAX_WIDTH);
    end else begin
      w_use = image_width;
    end
    h_use = (image_height < IMG_HEIGHT_W'(MIN_DIM)) ? IMG_HEIGHT_W'(MIN_DIM) : image_height;
  end

  // position of the incoming pixel and the one after it
  always_comb begin
    col_base = pixel.frame_start ? '0 : column_count;
    row_base = pixel.frame_start ? '0 : row_count;
    // a size change may leave the position outside the frame
    col_wrap = CMP_W'(col_base) >= CMP_W'(w_use);
    col_cur  = col_wrap ? '0 : col_base;
    row_inc  = {1'b0, row_base} + (IMG_HEIGHT_W+1)'(col_wrap);
    row_cur  = (row_inc >= {1'b0, h_use}) ? '0 : row_inc[IMG_HEIGHT_W-1:0];

    interior = (CMP_W'(col_cur) >= CMP_W'(2)) && (row_cur >= IMG_HEIGHT_W'(2));
    last     = (CMP_W'(col_cur) == CMP_W'(w_use) - CMP_W'(1))
            && (row_cur == h_use - IMG_HEIGHT_W'(1));

    col_step = CMP_W'(col_cur) + CMP_W'(1);
    col_end  = col_step >= CMP_W'(w_use);
    row_step = {1'b0, row_cur} + (IMG_HEIGHT_W+1)'(1);
    column_next = col_end ? '0 : col_step[COL_W-1:0];
    if (!col_end) begin
      row_next = row_cur;
    end else if (row_step >= {1'b0, h_use}) begin
      row_next = '0;
    end else begin
      row_next = row_step[IMG_HEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (pixel_accept) begin
      column_count <= column_next;
      row_count    <= row_next;
    end
  end

  // zero sweep over the line stores after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clearing   <= 1'b1;
      clear_addr <= '0;
    end else if (clearing) begin
      clear_addr <= clear_addr + COL_W'(1);
      if (clear_addr == COL_W'(MAX_WIDTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // stage 1 capture; bypass when the pixel ahead writes the column read now
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else begin
      s1_ctl.valid    <= pixel_accept;
      s1_ctl.interior <= interior;
      s1_ctl.last     <= last;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1_col           <= col_cur;
      s1_pixel         <= pixel.red_sample;
      s1_bypass        <= s1_ctl.valid && (s1_col == col_cur);
      s1_bypass_upper  <= middle_eff;
      s1_bypass_middle <= s1_pixel;
    end
  end

  // line stores
  assign upper_eff  = s1_bypass ? s1_bypass_upper  : upper_rd;
  assign middle_eff = s1_bypass ? s1_bypass_middle : middle_rd;

  always_comb begin
    ram_we       = clearing || s1_ctl.valid;
    ram_waddr    = clearing ? clear_addr : s1_col;
    upper_wdata  = clearing ? '0 : middle_eff;
    middle_wdata = clearing ? '0 : s1_pixel;
  end

  sobel_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_upper (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(upper_wdata),
    .re   (pixel_accept),
    .raddr(col_cur),
    .rdata(upper_rd)
  );

  sobel_ram #(
    .WIDTH(PIXEL_W),
    .DEPTH(MAX_WIDTH)
  ) u_line_middle (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(middle_wdata),
    .re   (pixel_accept),
    .raddr(col_cur),
    .rdata(middle_rd)
  );

  // window shift: old columns move left, new column enters at the right
  always_ff @(posedge clk) begin
    if (rst) begin
      window <= '0;
      s2_ctl <= '0;
    end else begin
      s2_ctl <= s1_ctl;
      if (s1_ctl.valid) begin
        window[0] <= window[1];
        window[1] <= window[2];
        window[3] <= window[4];
        window[4] <= window[5];
        window[6] <= window[7];
        window[7] <= window[8];
        window[2] <= upper_eff;
        window[5] <= middle_eff;
        window[8] <= s1_pixel;
      end
    end
  end

  // gradients, squares and threshold
  sobel_grad u_grad (
    .clk             (clk),
    .rst             (rst),
    .window          (window),
    .ctl_in          (s2_ctl),
    .threshold_square(threshold_square),
    .ctl_out         (s3_ctl),
    .push            (push),
    .result          (grad_result)
  );

  // output queue
  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= grad_result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr     <= '0;
      rd_ptr     <= '0;
      fifo_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + FIFO_AW'(1);
      end
      if (result_take) begin
        rd_ptr <= rd_ptr + FIFO_AW'(1);
      end
      fifo_count <= fifo_count + FIFO_CW'(push) - FIFO_CW'(result_take);
    end
  end

  // checks
  a_claim_bound: assert property (@(posedge clk) disable iff (rst)
    claimed <= (FIFO_CW+2)'(OUT_FIFO_DEPTH))
    else $error("output queue over-committed");

  a_no_push_full: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_count < FIFO_CW'(OUT_FIFO_DEPTH)) || result_take)
    else $error("push into a full output queue");

  a_clear_idle: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s1_ctl.valid && !s2_ctl.valid && !s3_ctl.valid && (fifo_count == '0))
    else $error("pixel in flight during line store sweep");

  a_bypass_same_col: assert property (@(posedge clk) disable iff (rst)
    (pixel_accept && s1_ctl.valid && (s1_col == col_cur)) |=> s1_bypass)
    else $error("line store bypass missed");

endmodule

// ===== sim/tb_sobel_edge_threshold_stream_top.sv =====
// Self-checking bench for sobel_edge_threshold_stream_top: raster pixels in, edge results out.
// Depends on sobel_pkg and the block's RTL; a scoreboard class predicts each result and
// checks it in order.
module tb_sobel_edge_threshold_stream_top;
  timeunit 1ns;
  timeprecision 1ps;
  import sobel_pkg::*;

  localparam int MAXW         = MAX_WIDTH_DEFAULT;
  localparam int IDLE_LIMIT   = 5000;  // covers the line store sweep and the long hold-off
  localparam int SETTLE       = 12;    // margin after the last result for the pipeline to empty
  localparam int HOLD_CYCLES  = 300;
  localparam int RANDOM_ITEMS = 2000;
  localparam int MAX_REPORTS  = 20;

  typedef enum {TEX_NOISE, TEX_SMOOTH, TEX_BLOCKS, TEX_RAMP} texture_t;

  logic                   clk;
  logic                   rst;
  logic                   pixel_valid;
  logic                   pixel_stall;
  pixel_t                 pixel;
  logic                   result_valid;
  logic                   result_stall;
  result_t                result;
  logic                   cfg_write;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  bit          quiet;         // no idling on either side
  bit          steady_rows;   // no stray frame_start mid-frame
  bit          hold_pending;  // asks the receiver for one long hold-off
  int unsigned pixels_taken;
  int unsigned results_taken;

  sobel_edge_threshold_stream_top #(.MAX_WIDTH(MAXW)) dut (
    .clk          (clk),
    .rst          (rst),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .pixel        (pixel),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  // Edge predictor: own copy of line stores, window, position and registers
  class edge_scoreboard;
    bit [PIXEL_W-1:0] upper_line [MAXW];
    bit [PIXEL_W-1:0] middle_line [MAXW];
    bit [PIXEL_W-1:0] win [9];
    int unsigned      col_pos, row_pos;
    int unsigned      width_reg, height_reg, thresh_reg;
    result_t          expected_q [$];
    int unsigned      mismatches, checked, edges, frame_ends;

    function new();
      width_reg  = 32'(IMAGE_WIDTH_RESET);
      height_reg = 32'(IMAGE_HEIGHT_RESET);
      thresh_reg = 32'(THRESHOLD_RESET);
      col_pos    = 0;
      row_pos    = 0;
      mismatches = 0;
      checked    = 0;
      edges      = 0;
      frame_ends = 0;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_IMAGE_WIDTH:      width_reg  = 32'(v[IMG_WIDTH_W-1:0]);
        REG_IMAGE_HEIGHT:     height_reg = 32'(v[IMG_HEIGHT_W-1:0]);
        REG_THRESHOLD_SQUARE: thresh_reg = 32'(v[THRESH_W-1:0]);
        default: ;
      endcase
    endfunction

    function int unsigned width_used();
      if (width_reg < MIN_DIM) return MIN_DIM;
      if (width_reg > MAXW) return MAXW;
      return width_reg;
    endfunction

    function int unsigned height_used();
      return (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
    endfunction

    // One accepted pixel: update window and line stores, queue a result if interior
    function void note_pixel(pixel_t px);
      int unsigned w, h, c, r;
      int          gx, gy, mag, i;
      result_t     want;
      w = width_used();
      h = height_used();
      if (px.frame_start) begin
        col_pos = 0;
        row_pos = 0;
      end
      // position left beyond a shrunk size
      if (col_pos >= w) begin
        col_pos = 0;
        row_pos++;
      end
      if (row_pos >= h) row_pos = 0;
      c = col_pos;
      r = row_pos;

      for (i = 0; i < 3; i++) begin
        win[i*3]   = win[i*3+1];
        win[i*3+1] = win[i*3+2];
      end
      win[2] = upper_line[c];
      win[5] = middle_line[c];
      win[8] = px.red_sample;
      upper_line[c]  = middle_line[c];
      middle_line[c] = px.red_sample;

      if (c >= 2 && r >= 2) begin
        gx = (int'(win[2]) + 2 * int'(win[5]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[3]) + int'(win[6]));
        gy = (int'(win[6]) + 2 * int'(win[7]) + int'(win[8]))
           - (int'(win[0]) + 2 * int'(win[1]) + int'(win[2]));
        mag = gx * gx + gy * gy;
        want.edge_value = (mag > int'(thresh_reg)) ? EDGE_PIXEL : PLAIN_PIXEL;
        want.frame_last = (c == w - 1) && (r == h - 1);
        expected_q.push_back(want);
      end

      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      col_pos = c;
      row_pos = r;
    endfunction

    // One accepted result against the oldest expectation
    function void check_result(result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: result with nothing expected: edge_value=%0d frame_last=%0b",
                   $time, got.edge_value, got.frame_last);
        return;
      end
      want = expected_q.pop_front();
      checked++;
      if (want.edge_value == EDGE_PIXEL) edges++;
      if (want.frame_last) frame_ends++;
      if (got.edge_value !== want.edge_value) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: edge_value expected %0d, actual %0d",
                   $time, want.edge_value, got.edge_value);
      end
      if (got.frame_last !== want.frame_last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("%0t: frame_last expected %0b, actual %0b",
                   $time, want.frame_last, got.frame_last);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  edge_scoreboard sb;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Snapshot at the falling edge: what is seen here is what the next rising edge takes
  always @(negedge clk) begin
    if (!rst) begin
      if (result_valid && !result_stall) begin
        sb.check_result(result);
        results_taken++;
      end
      if (pixel_valid && !pixel_stall) begin
        sb.note_pixel(pixel);
        pixels_taken++;
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request
  initial begin : receiver
    result_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_pending) begin
        hold_pending = 1'b0;
        result_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        result_stall <= 1'b0;
      end else begin
        result_stall <= !quiet && ($urandom_range(0, 99) < 9);
      end
    end
  end

  // Watchdog: ends the run if no request moves on either side for too long
  initial begin : watchdog
    int unsigned stuck_cycles;
    int unsigned last_total;
    stuck_cycles = 0;
    last_total   = 0;
    while (stuck_cycles < IDLE_LIMIT) begin
      @(posedge clk);
      if (pixels_taken + results_taken != last_total) begin
        last_total   = pixels_taken + results_taken;
        stuck_cycles = 0;
      end else begin
        stuck_cycles++;
      end
    end
    $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
    $display("TB_ERROR");
    $finish;
  end

  // Offer one pixel request, with an occasional idle cycle first, and wait until taken
  task automatic send_pixel(input logic [PIXEL_W-1:0] r, input logic fs);
    pixel_t px;
    bit     took;
    px.red_sample  = r;
    px.frame_start = fs;
    if (!quiet && $urandom_range(0, 99) < 9) begin
      pixel_valid <= 1'b0;
      @(posedge clk);
    end
    pixel_valid <= 1'b1;
    pixel       <= px;
    do begin
      @(negedge clk);
      took = !pixel_stall;
      @(posedge clk);
    end while (!took);
  endtask

  // Stop offering, wait for every expected result, then let the pipeline empty
  task automatic settle();
    pixel_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write the registers selected by mask (bit position = register index)
  task automatic apply_config(input bit [2:0] mask, input int unsigned w, h, t);
    logic [CFG_DATA_W-1:0] vals [3];
    cfg_reg_t              idx;
    vals[REG_IMAGE_WIDTH]      = CFG_DATA_W'(w);
    vals[REG_IMAGE_HEIGHT]     = CFG_DATA_W'(h);
    vals[REG_THRESHOLD_SQUARE] = CFG_DATA_W'(t);
    idx = idx.first();
    repeat (idx.num()) begin
      if (mask[idx]) begin
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= vals[idx];
        @(posedge clk);
        sb.write_reg(idx, vals[idx]);
      end
      idx = idx.next();
    end
    cfg_write <= 1'b0;
  endtask

  // Stream of frames with textured content; frame_start on most frame boundaries,
  // rarely a stray one mid-frame
  task automatic run_frames(input int unsigned n_items, input int unsigned fsize,
                            input texture_t tex, input bit first_fs);
    int unsigned        k;
    logic [PIXEL_W-1:0] v, base, step;
    logic               fs;
    base = PIXEL_W'($urandom_range(0, 247));
    step = PIXEL_W'($urandom_range(1, 40));
    v    = '0;
    for (k = 0; k < n_items; k++) begin
      case (tex)
        TEX_NOISE:  v = PIXEL_W'($urandom_range(0, 255));
        TEX_SMOOTH: v = base + PIXEL_W'($urandom_range(0, 8));
        TEX_BLOCKS: if ($urandom_range(0, 7) == 0) v = ~v;
        default:    v = PIXEL_W'(k) * step;
      endcase
      if (k == 0)
        fs = first_fs;
      else if (k % fsize == 0)
        fs = ($urandom_range(0, 3) != 0);
      else
        fs = !steady_rows && ($urandom_range(0, 99) == 0);
      send_pixel(v, fs);
    end
  endtask

  // Stimulus
  initial begin : stimulus
    int unsigned random_items, phase, settings, w, h, t, n, fsize, pick, k;
    bit [2:0]    mask;
    bit          first_fs;
    texture_t    tex;

    sb           = new();
    rst          <= 1'b1;
    pixel_valid  <= 1'b0;
    pixel        <= '0;
    cfg_write    <= 1'b0;
    cfg_index    <= REG_IMAGE_WIDTH;
    cfg_data     <= '0;
    quiet        = 1'b0;
    steady_rows  = 1'b0;
    hold_pending = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Sizes below range clamp to 3x3; zero threshold
    apply_config(3'b111, 2, 0, 0);
    settings = 1;
    // vertical step: strong gradient, an edge even for a tiny threshold
    for (k = 0; k < 9; k++)
      send_pixel((k % 3 == 2) ? 8'hFF : 8'h00, k == 0);
    // next frame after wrap without frame_start, flat: magnitude equals threshold
    for (k = 0; k < 9; k++)
      send_pixel(8'hFF, 1'b0);
    settle();

    random_items = 0;
    phase        = 0;
    while (random_items < RANDOM_ITEMS) begin
      mask     = 3'b111;
      tex      = texture_t'($urandom_range(0, 3));
      first_fs = 1'b1;
      case (phase)
        0: begin  // receiver holds off long while pixels keep coming
          w = 6; h = 40; t = 32'(THRESHOLD_RESET); n = 240; tex = TEX_NOISE;
          hold_pending = 1'b1;
        end
        1: begin  // stretch with no idling on either side
          w = 10; h = 12; t = $urandom_range(0, 200000); n = 360;
          quiet = 1'b1;
        end
        2: begin  // widest frame, width beyond range clamps; row 2 reached on a 3x3 frame
          apply_config(3'b111, 3, 3, 32'(THRESHOLD_RESET));
          settings++;
          for (k = 0; k < 6; k++)
            send_pixel(PIXEL_W'($urandom_range(0, 255)), k == 0);
          settle();
          mask = 3'b001; w = 2047; h = 3; t = 32'(THRESHOLD_RESET); n = MAXW + 8;
          tex = TEX_BLOCKS; first_fs = 1'b0; steady_rows = 1'b1;
        end
        3: begin  // tallest height, largest threshold, partial frame
          w = 5; h = 65535; t = (1 << THRESH_W) - 1; n = 103;
        end
        4: begin  // shrink both sizes below the current position
          mask = 3'b011; w = 3; h = 4; t = 0; n = 60; tex = TEX_NOISE;
          first_fs = 1'b0;
        end
        default: begin
          mask = 3'($urandom_range(1, 7));
          pick = $urandom_range(0, 99);
          if (pick < 70)      w = $urandom_range(3, 12);
          else if (pick < 80) w = $urandom_range(0, 2);
          else if (pick < 93) w = $urandom_range(13, 64);
          else                w = $urandom_range(65, 2047);
          pick = $urandom_range(0, 99);
          if (pick < 75)      h = $urandom_range(3, 10);
          else if (pick < 85) h = $urandom_range(0, 2);
          else                h = $urandom_range(11, 65535);
          pick = $urandom_range(0, 99);
          if (pick < 30)      t = 32'(THRESHOLD_RESET);
          else if (pick < 50) t = $urandom_range(0, 200000);
          else if (pick < 60) t = 0;
          else if (pick < 70) t = (1 << THRESH_W) - 1;
          else                t = $urandom & ((1 << THRESH_W) - 1);
          first_fs = ($urandom_range(0, 3) != 0);
        end
      endcase
      apply_config(mask, w, h, t);
      settings++;
      fsize = sb.width_used() * sb.height_used();
      if (phase > 4) begin
        if (fsize <= 400) begin
          n = fsize * $urandom_range(1, 3);
          // now and then a frame cut short
          if ($urandom_range(0, 9) == 0) n += $urandom_range(1, fsize - 1);
        end else begin
          n = $urandom_range(30, 200);
        end
      end
      run_frames(n, fsize, tex, first_fs);
      settle();
      quiet       = 1'b0;
      steady_rows = 1'b0;
      random_items += n;
      phase++;
    end

    $display("Covered %0d pixels and %0d results (%0d edges, %0d frame ends) in %0d phases",
             pixels_taken, sb.checked, sb.edges, sb.frame_ends, phase);
    $display("over %0d register settings, with one long result hold-off and a no-idle stretch",
             settings);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
